>>> src/bas_pkg.sv
// ----------------------------------------------------------------------------
// bas_pkg: shared types for the breakpoint address set
// Action and status codes, the control FSM state type and the token that
// walks the cell chain.
// ----------------------------------------------------------------------------
package bas_pkg;

	localparam int unsigned AddrW  = 16;
	localparam int unsigned CountW = 5;

	typedef enum logic [1:0] {
		ACT_LOOKUP = 2'd0,
		ACT_ADD    = 2'd1,
		ACT_DELETE = 2'd2,
		ACT_CLEAR  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_DUPLICATE = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SEARCH,
		FSM_WRITE,
		FSM_HOLD
	} fsm_t;

	// Token handed from cell to cell, one cell per cycle.
	// free: in the search pass, a free cell was seen; in the write pass,
	// the address has been placed.
	typedef struct packed {
		logic              vld;
		logic              pass2;
		action_t           action;
		logic [AddrW-1:0]  address;
		logic              hit;
		logic              free;
	} tok_t;

endpackage

>>> src/breakpoint_address_set.sv
// ----------------------------------------------------------------------------
// breakpoint_address_set: set of 16-bit breakpoint addresses
// Look up, add, delete and clear all over a chain of MAX_BREAKPOINTS cells.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Beat contents (low bit first)
// s_*       in   action[1:0], address[17:2], zero pad to 24 bits
// m_*       out  hit[0], status[2:1], entry_count[7:3]
//
// One action at a time. A token enters cell 0 and moves one cell per clock,
// so the search pass visits every cell of the chain; an add that finds
// no duplicate and a free cell makes a second pass down the chain to
// place the address in the lowest free cell. The result then waits in
// the hold state until the output register frees and is registered there.
// s_tready is high only while no action is in the chain. A result that the
// sink does not take waits in the output register; the next action may run
// meanwhile and holds its own result until the register frees.
// Reset clears every valid bit and the count at once; stored addresses are
// never read while their cell is invalid.
// ----------------------------------------------------------------------------
module breakpoint_address_set #(
	parameter int unsigned MAX_BREAKPOINTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // action[1:0], address[17:2], zeros[23:18]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // hit[0], status[2:1], entry_count[7:3]
);

	// Count register just wide enough for a full store.
	localparam int unsigned CntW = $clog2(MAX_BREAKPOINTS + 1);

	bas_pkg::tok_t  tok [MAX_BREAKPOINTS+1];
	bas_pkg::tok_t  launch;
	bas_pkg::tok_t  tok_end;

	bas_pkg::fsm_t    state_q, state_d;
	logic [CntW-1:0]  cnt_q, cnt_d;
	logic             res_hit_q, res_hit_d;
	bas_pkg::status_t res_st_q, res_st_d;
	logic             m_tvalid_q, m_tvalid_d;
	logic [7:0]       m_tdata_q, m_tdata_d;
	logic             out_free;

	// Row of cells; token i+1 is the registered output of cell i.
	assign tok[0] = launch;

	for (genvar i = 0; i < MAX_BREAKPOINTS; i++) begin : g_cell
		bas_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tok_in (tok[i]),
			.tok_out(tok[i+1])
		);
	end

	assign tok_end  = tok[MAX_BREAKPOINTS];
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == bas_pkg::FSM_IDLE);

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		res_hit_d  = res_hit_q;
		res_st_d   = res_st_q;
		launch     = '0;
		m_tvalid_d = m_tvalid_q && !m_tready;
		m_tdata_d  = m_tdata_q;

		unique case (state_q)
			bas_pkg::FSM_IDLE: begin
				if (s_tvalid) begin
					// launch the search pass
					launch.vld     = 1'b1;
					launch.action  = bas_pkg::action_t'(s_tdata[1:0]);
					launch.address = s_tdata[17:2];
					state_d        = bas_pkg::FSM_SEARCH;
				end
			end
			bas_pkg::FSM_SEARCH: begin
				if (tok_end.vld) begin
					res_hit_d = tok_end.hit;
					res_st_d  = bas_pkg::ST_OK;
					state_d   = bas_pkg::FSM_HOLD;
					unique case (tok_end.action)
						bas_pkg::ACT_LOOKUP: begin
						end
						bas_pkg::ACT_ADD: begin
							if (tok_end.hit) begin
								res_st_d = bas_pkg::ST_DUPLICATE;
							end else if (!tok_end.free) begin
								res_st_d = bas_pkg::ST_FULL;
							end else begin
								// send the address round again to claim a cell
								launch.vld     = 1'b1;
								launch.pass2   = 1'b1;
								launch.action  = bas_pkg::ACT_ADD;
								launch.address = tok_end.address;
								state_d        = bas_pkg::FSM_WRITE;
							end
						end
						bas_pkg::ACT_DELETE: begin
							if (tok_end.hit) begin
								cnt_d = cnt_q - CntW'(1);
							end else begin
								res_st_d = bas_pkg::ST_NOT_FOUND;
							end
						end
						bas_pkg::ACT_CLEAR: begin
							cnt_d = '0;
						end
					endcase
				end
			end
			bas_pkg::FSM_WRITE: begin
				if (tok_end.vld) begin
					cnt_d   = cnt_q + CntW'(1);
					state_d = bas_pkg::FSM_HOLD;
				end
			end
			bas_pkg::FSM_HOLD: begin
				// hold until the output register frees
				if (out_free) begin
					m_tvalid_d = 1'b1;
					m_tdata_d  = {bas_pkg::CountW'(cnt_q), res_st_q, res_hit_q};
					state_d    = bas_pkg::FSM_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= bas_pkg::FSM_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			cnt_q      <= cnt_d;
			m_tvalid_q <= m_tvalid_d;
		end
	end

	always_ff @(posedge clk) begin
		res_hit_q <= res_hit_d;
		res_st_q  <= res_st_d;
		m_tdata_q <= m_tdata_d;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

>>> src/bas_cell.sv
// ----------------------------------------------------------------------------
// bas_cell: one entry of the breakpoint chain
// Holds one address and its valid bit, checks the passing token against it
// and registers the token for the next cell.
// ----------------------------------------------------------------------------
module bas_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  bas_pkg::tok_t tok_in,
	output bas_pkg::tok_t tok_out
);

	logic                      valid_q;
	logic                      valid_d;
	logic [bas_pkg::AddrW-1:0] addr_q;
	logic                      wr;
	logic                      match;
	bas_pkg::tok_t             tok_q;
	bas_pkg::tok_t             tok_d;

	assign match = valid_q && (addr_q == tok_in.address);

	always_comb begin
		tok_d   = tok_in;
		valid_d = valid_q;
		wr      = 1'b0;
		if (tok_in.vld) begin
			if (!tok_in.pass2) begin
				tok_d.hit  = tok_in.hit | match;
				tok_d.free = tok_in.free | !valid_q;
				unique case (tok_in.action)
					bas_pkg::ACT_LOOKUP, bas_pkg::ACT_ADD: begin
					end
					bas_pkg::ACT_DELETE: begin
						if (match) begin
							valid_d = 1'b0;
						end
					end
					bas_pkg::ACT_CLEAR: begin
						valid_d = 1'b0;
					end
				endcase
			end else if (!tok_in.free && !valid_q) begin
				// claim the lowest free cell
				valid_d    = 1'b1;
				wr         = 1'b1;
				tok_d.free = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= '0;
		end else begin
			valid_q <= valid_d;
			tok_q   <= tok_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			addr_q <= tok_in.address;
		end
	end

	assign tok_out = tok_q;

endmodule

>>> src/bas_checker.sv
// ----------------------------------------------------------------------------
// bas_checker: port-level checks for the breakpoint address set
// Watches the result stream for handshake slips and inconsistent results.
// ----------------------------------------------------------------------------
module bas_checker #(
	parameter int unsigned MAX_BREAKPOINTS = 16
) (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata
);

	// stalled result stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	// stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result payload changed while stalled");

	// a duplicate is always a hit
	a_dup_hit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:1] == bas_pkg::ST_DUPLICATE) |-> m_tdata[0])
		else $error("duplicate reported without hit");

	// full table and not found never hit
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ((m_tdata[2:1] == bas_pkg::ST_FULL) ||
			(m_tdata[2:1] == bas_pkg::ST_NOT_FOUND)) |-> !m_tdata[0])
		else $error("miss status reported with hit");

	// count never exceeds the store size
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (MAX_BREAKPOINTS > 31) || (32'(m_tdata[7:3]) <= MAX_BREAKPOINTS))
		else $error("entry count beyond store size");

endmodule

bind breakpoint_address_set bas_checker #(
	.MAX_BREAKPOINTS(MAX_BREAKPOINTS)
) u_bas_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

>>> sim/tb_breakpoint_address_set.sv
// ----------------------------------------------------------------------------
// tb_breakpoint_address_set: self-checking bench for the breakpoint set
// Streams look-up, add, delete and clear-all beats into the block, predicts
// each result from a local copy of the stored addresses, and compares every
// output beat field by field, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_breakpoint_address_set;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAX_BP    = 16;
	// A successful add walks the chain twice, plus the output stage.
	localparam int          LATENCY   = 2 * MAX_BP + 2;
	localparam int          IDLE_MAX  = 19;
	localparam int          LONG_HOLD = 300;
	localparam int          HOLD_AT   = 300;   // result count that starts the long hold
	localparam int          WATCHDOG  = 2000;
	localparam int          N_RANDOM  = 925;
	localparam int          POOL_N    = 24;

	typedef struct {
		bas_pkg::action_t          act;
		logic [bas_pkg::AddrW-1:0] addr;
	} bp_request_t;

	typedef struct {
		logic                       hit;
		bas_pkg::status_t           st;
		logic [bas_pkg::CountW-1:0] count;
	} bp_outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;

	// Requests waiting to be driven, and outcomes waiting to be seen.
	bp_request_t request_q[$];
	bp_outcome_t outcome_q[$];

	// Local copy of the set.
	logic [bas_pkg::AddrW-1:0] slot_addr [MAX_BP];
	bit                        slot_used [MAX_BP];
	int                        used_count = 0;

	int  beats_in = 0;
	int  beats_out = 0;
	int  total_requests = 0;
	int  errors = 0;
	bit  in_taken = 1'b0;    // an input beat moved at the last rising edge
	bit  out_taken = 1'b0;   // an output beat moved at the last rising edge

	breakpoint_address_set #(
		.MAX_BREAKPOINTS(MAX_BP)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),   // action[1:0], address[17:2], zeros[23:18]
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)    // hit[0], status[2:1], entry_count[7:3]
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one action to the local set and return what the block must answer.
	// Hit is always taken before the action changes anything, clear included.
	function automatic bp_outcome_t apply_action(bas_pkg::action_t act,
			logic [bas_pkg::AddrW-1:0] a);
		bp_outcome_t o;
		int found;
		int free_i;
		found = -1;
		free_i = -1;
		for (int i = 0; i < MAX_BP; i++) begin
			if (slot_used[i] && slot_addr[i] == a && found < 0)
				found = i;
			if (!slot_used[i] && free_i < 0)
				free_i = i;
		end
		o.hit = (found >= 0);
		o.st  = bas_pkg::ST_OK;
		case (act)
			bas_pkg::ACT_ADD: begin
				if (found >= 0) begin
					o.st = bas_pkg::ST_DUPLICATE;
				end else if (free_i < 0) begin
					o.st = bas_pkg::ST_FULL;
				end else begin
					slot_addr[free_i] = a;
					slot_used[free_i] = 1'b1;
					used_count++;
				end
			end
			bas_pkg::ACT_DELETE: begin
				if (found >= 0) begin
					slot_used[found] = 1'b0;
					used_count--;
				end else begin
					o.st = bas_pkg::ST_NOT_FOUND;
				end
			end
			bas_pkg::ACT_CLEAR: begin
				for (int i = 0; i < MAX_BP; i++)
					slot_used[i] = 1'b0;
				used_count = 0;
			end
			default: ;
		endcase
		o.count = used_count[bas_pkg::CountW-1:0];
		return o;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("[%0t] beat %0d: %s got %0h, want %0h", $realtime, beats_out, what, got, want);
		errors++;
	endtask

	task automatic push_request(bas_pkg::action_t act, logic [bas_pkg::AddrW-1:0] a);
		bp_request_t r;
		r.act  = act;
		r.addr = a;
		request_q.push_back(r);
	endtask

	// ------------------------------------------------------------------------
	// Sender: advance on the falling edge. Hold the current beat until it is
	// taken, then wait the drawn number of cycles before offering the next.
	// ------------------------------------------------------------------------
	bp_request_t cur_req;
	bit          have_req = 1'b0;
	int          send_wait = 0;
	bit          send_burst = 1'b0;

	always @(negedge clk) begin
		if (arst_n && !(s_tvalid && !in_taken)) begin
			if (!have_req && request_q.size() > 0) begin
				cur_req = request_q.pop_front();
				have_req = 1'b1;
				if ($urandom_range(0, 39) == 0)
					send_burst = !send_burst;
				send_wait = send_burst ? 0 : $urandom_range(0, IDLE_MAX);
			end
			if (have_req && send_wait == 0) begin
				s_tvalid <= 1'b1;
				s_tdata  <= {6'b0, cur_req.addr, cur_req.act};
				have_req = 1'b0;
			end else begin
				s_tvalid <= 1'b0;
				if (have_req)
					send_wait--;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: after each result, drop tready for a drawn number of cycles.
	// Once, hold off for a long stretch so the block fills and stalls input.
	// ------------------------------------------------------------------------
	int  hold_left = 0;
	bit  recv_burst = 1'b0;
	bit  long_done = 1'b0;

	always @(negedge clk) begin
		int n;
		n = 0;
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (out_taken) begin
				if ($urandom_range(0, 39) == 0)
					recv_burst = !recv_burst;
				n = recv_burst ? 0 : $urandom_range(0, IDLE_MAX);
				if (!long_done && beats_out >= HOLD_AT) begin
					n = LONG_HOLD;
					long_done = 1'b1;
				end
				if (n == 0) begin
					m_tready <= 1'b1;
				end else begin
					m_tready <= 1'b0;
					hold_left = n - 1;
				end
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: sample both channels on the rising edge. Predict on each input
	// beat, check each output beat against the oldest prediction.
	// ------------------------------------------------------------------------
	int idle_cycles = 0;

	always @(posedge clk) begin
		bp_outcome_t want;
		in_taken  <= s_tvalid && s_tready;
		out_taken <= m_tvalid && m_tready;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				outcome_q.push_back(apply_action(bas_pkg::action_t'(s_tdata[1:0]),
					s_tdata[17:2]));
				beats_in++;
			end
			if (m_tvalid && m_tready) begin
				if (outcome_q.size() == 0) begin
					report_mismatch("unexpected result", m_tdata, 0);
				end else begin
					want = outcome_q.pop_front();
					if (m_tdata[0] !== want.hit)
						report_mismatch("hit", m_tdata[0], want.hit);
					if (m_tdata[2:1] !== want.st)
						report_mismatch("status", m_tdata[2:1], want.st);
					if (m_tdata[7:3] !== want.count)
						report_mismatch("entry_count", m_tdata[7:3], want.count);
				end
				beats_out++;
			end
			// Watchdog: count cycles in which neither channel moves a beat.
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus and end of run.
	// ------------------------------------------------------------------------
	initial begin
		logic [bas_pkg::AddrW-1:0] pool [POOL_N];
		logic [bas_pkg::AddrW-1:0] a;
		bit                        filling;
		int                        r;
		bas_pkg::action_t          act;

		for (int i = 0; i < MAX_BP; i++)
			slot_used[i] = 1'b0;

		// Directed: empty look-up, both address extremes, duplicate add,
		// delete of an absent address, reuse of the lowest free slot,
		// fill to capacity, add to a full set, clear with a stored address,
		// then delete after clear.
		push_request(bas_pkg::ACT_LOOKUP, 16'h0000);
		push_request(bas_pkg::ACT_ADD,    16'h0000);
		push_request(bas_pkg::ACT_ADD,    16'hFFFF);
		push_request(bas_pkg::ACT_ADD,    16'hFFFF);
		push_request(bas_pkg::ACT_LOOKUP, 16'hFFFF);
		push_request(bas_pkg::ACT_DELETE, 16'h1234);
		push_request(bas_pkg::ACT_DELETE, 16'h0000);
		for (int i = 1; i <= 15; i++)
			push_request(bas_pkg::ACT_ADD, 16'(i * 16'h1001));
		push_request(bas_pkg::ACT_ADD,    16'h0001);
		push_request(bas_pkg::ACT_CLEAR,  16'hFFFF);
		push_request(bas_pkg::ACT_DELETE, 16'hFFFF);

		// Random: draw addresses mostly from a small pool so that hits,
		// duplicates and a full set happen often; draw fill or drain at random
		// for each phase of 64 requests; keep some fully random addresses as noise.
		for (int i = 0; i < POOL_N; i++)
			pool[i] = 16'($urandom_range(0, 16'hFFFF));
		filling = 1'b1;
		for (int k = 0; k < N_RANDOM; k++) begin
			if (k % 64 == 0)
				filling = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 9) == 0)
				pool[$urandom_range(0, POOL_N - 1)] = 16'($urandom_range(0, 16'hFFFF));
			if ($urandom_range(0, 99) < 15)
				a = 16'($urandom_range(0, 16'hFFFF));
			else
				a = pool[$urandom_range(0, POOL_N - 1)];
			r = $urandom_range(0, 99);
			if (r < 2)
				act = bas_pkg::ACT_CLEAR;
			else if (r < (filling ? 62 : 27))
				act = bas_pkg::ACT_ADD;
			else if (r < (filling ? 77 : 72))
				act = bas_pkg::ACT_DELETE;
			else
				act = bas_pkg::ACT_LOOKUP;
			push_request(act, a);
		end
		total_requests = request_q.size();

		// Hold reset, then release it away from the rising edge.
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (beats_in == total_requests);
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 6) @(posedge clk);

		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> breakpoint_address_set.f
src/bas_pkg.sv
src/bas_cell.sv
src/breakpoint_address_set.sv
src/bas_checker.sv
sim/tb_breakpoint_address_set.sv
